// ===== src/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants of the conditional probability table: opcodes,
// status codes, register indexes and the field widths of the item streams.
// ----------------------------------------------------------------------------
package cpt_pkg;

   // Field widths of the item streams.
   localparam int OPCODE_BITS    = 2;
   localparam int INDEX_BITS     = 4;
   localparam int CFG_BITS       = 5;
   localparam int PROB_BITS      = 17;
   localparam int OUT_COUNT_BITS = 16;
   localparam int STATUS_BITS    = 2;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 56;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - PROB_BITS - 2 * OUT_COUNT_BITS;

   // Fixed point: 1.0 is 2^FRAC_BITS; a quotient takes one bit per step.
   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = PROB_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);
   localparam logic [PROB_BITS-1:0] ONE_FIXED = PROB_BITS'(1 << FRAC_BITS);

   // Configuration port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam logic [CSR_IDX_BITS-1:0] REG_NUM_CLASSES = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ATTRIB_SIZE = 1'b1;
   localparam logic [CFG_BITS-1:0]     CFG_RESET_VALUE = 5'd16;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_SAT   = 2'd2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ACCUM = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] num_classes;
      logic [CFG_BITS-1:0] attrib_size;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== src/cpt_ram.sv =====
// ----------------------------------------------------------------------------
// cpt_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cpt_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cpt_csr.sv =====
// ----------------------------------------------------------------------------
// cpt_csr
// Configuration registers behind the APB-style port: class count and
// attribute size used for the bounds checks.
// ----------------------------------------------------------------------------
module cpt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cpt_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [cpt_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [cpt_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output cpt_pkg::cfg_type                    cfg
);
   import cpt_pkg::*;

   logic [CFG_BITS-1:0]     num_classes_ff, num_classes_in;
   logic [CFG_BITS-1:0]     attrib_size_ff, attrib_size_in;
   logic [CSR_IDX_BITS-1:0] reg_idx;
   logic                    wr_strobe;

   // Registers sit on a 4-byte stride.
   assign reg_idx    = csr_paddr[2 +: CSR_IDX_BITS];
   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      num_classes_in = num_classes_ff;
      attrib_size_in = attrib_size_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            REG_NUM_CLASSES: num_classes_in = csr_pwdata[CFG_BITS-1:0];
            REG_ATTRIB_SIZE: attrib_size_in = csr_pwdata[CFG_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NUM_CLASSES: csr_prdata = CSR_DATA_BITS'(num_classes_ff);
         REG_ATTRIB_SIZE: csr_prdata = CSR_DATA_BITS'(attrib_size_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= CFG_RESET_VALUE;
         attrib_size_ff <= CFG_RESET_VALUE;
      end else begin
         num_classes_ff <= num_classes_in;
         attrib_size_ff <= attrib_size_in;
      end
   end

   assign cfg.num_classes = num_classes_ff;
   assign cfg.attrib_size = attrib_size_ff;

endmodule

// ===== src/cpt_divider.sv =====
// ----------------------------------------------------------------------------
// cpt_divider
// Restoring divider for (pair count * 2^16) / value count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module cpt_divider #(
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_BITS-1:0]             dividend,
   input  logic [COUNT_BITS-1:0]             divisor,
   output logic [cpt_pkg::PROB_BITS-1:0]     quotient,
   output cpt_pkg::div_stat_type             stat
);
   import cpt_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] dvs_ff, dvs_in;
   logic [PROB_BITS-1:0]  quo_ff, quo_in;
   logic                  bit_ff, bit_in;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   // The pair count never exceeds the value count, so the quotient fits in
   // 17 bits. The dividend bits above bit 16 then leave pair_count >> 1 as
   // the partial remainder; only pair_count[0] and sixteen zeros remain.
   assign trial = {rem_ff, bit_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend[COUNT_BITS-1:1]};
         bit_in  = dividend[0];
         dvs_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? COUNT_BITS'(trial - {1'b0, dvs_ff}) : trial[COUNT_BITS-1:0];
         quo_in  = {quo_ff[PROB_BITS-2:0], fits};
         bit_in  = 1'b0;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== src/conditional_probability_table.sv =====
// Sequencing: an accepted item reads both count RAMs; an accumulate then passes S_EXEC
// and S_DONE, a query S_EXEC, S_DIV (the bit-serial divider, skipped when the value
// count is zero) and S_DONE.
// Flow: one item at a time; a clear sweeps every pair entry before it answers.
// Reset: synchronous; after reset the block sweeps zeros through both RAMs
// (MAX_VALUES*MAX_CLASSES pair entries, 256 by default) before it takes an item.
// ----------------------------------------------------------------------------
// conditional_probability_table
// Per (attribute value, class) and per value training counts held in RAMs,
// with read-modify-write accumulation and a probability query.
// ----------------------------------------------------------------------------
module conditional_probability_table #(
   parameter int MAX_VALUES  = 16,
   parameter int MAX_CLASSES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: attribute_value[3:0], class_value[7:4]
   input  logic [cpt_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [cpt_pkg::OPCODE_BITS-1:0]      req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: probability[16:0], pair_count[32:17], value_total[48:33], zeros
   output logic [cpt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [cpt_pkg::STATUS_BITS-1:0]      rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cpt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [cpt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [cpt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import cpt_pkg::*;

   localparam int PAIR_DEPTH = MAX_VALUES * MAX_CLASSES;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
   localparam int VAL_AW     = $clog2(MAX_VALUES);
   localparam int LIM_BITS   = 9;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_DIV   = 5'b00100,
      S_CLEAR = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   cfg_type      cfg;
   div_stat_type div_stat;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [PAIR_AW-1:0]   pair_addr_ff, pair_addr_in;
   logic [VAL_AW-1:0]    val_addr_ff, val_addr_in;
   logic [PAIR_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                 clr_resp_ff, clr_resp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PROB_BITS-1:0]      res_prob_ff, res_prob_in;
   logic [OUT_COUNT_BITS-1:0] res_pc_ff, res_pc_in;
   logic [OUT_COUNT_BITS-1:0] res_vt_ff, res_vt_in;
   logic [STATUS_BITS-1:0]    res_status_ff, res_status_in;
   logic [RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]    rsp_user_ff, rsp_user_in;

   opcode_type           req_op;
   logic [INDEX_BITS-1:0] req_val;
   logic [INDEX_BITS-1:0] req_cls;
   logic                 req_accept;
   logic                 in_range;
   logic [PAIR_AW-1:0]   req_pair_addr;

   logic                  pair_wr_en, val_wr_en;
   logic [PAIR_AW-1:0]    pair_wr_addr;
   logic [VAL_AW-1:0]     val_wr_addr;
   logic [COUNT_BITS-1:0] pair_wr_data, val_wr_data;
   logic [COUNT_BITS-1:0] pc_rd, vt_rd;
   logic [COUNT_BITS-1:0] pc_inc, vt_inc;
   logic                  div_start;
   logic [PROB_BITS-1:0]  quotient;
   logic [PROB_BITS-1:0]  prob_clamped;

   cpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cpt_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_pair_addr),
      .rd_data (pc_rd)
   );

   cpt_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_VALUES)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (req_accept),
      .rd_addr (VAL_AW'(req_val)),
      .rd_data (vt_rd)
   );

   cpt_divider #(.COUNT_BITS(COUNT_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pc_rd),
      .divisor  (vt_rd),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign req_op     = opcode_type'(req_tuser);
   assign req_val    = req_tdata[INDEX_BITS-1:0];
   assign req_cls    = req_tdata[2*INDEX_BITS-1:INDEX_BITS];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Both the register and the table size bound each index.
   assign in_range = (CFG_BITS'(req_val) < cfg.attrib_size)
                  && (LIM_BITS'(req_val) < LIM_BITS'(MAX_VALUES))
                  && (CFG_BITS'(req_cls) < cfg.num_classes)
                  && (LIM_BITS'(req_cls) < LIM_BITS'(MAX_CLASSES));
   assign req_pair_addr = PAIR_AW'(int'(req_val) * MAX_CLASSES + int'(req_cls));

   assign pc_inc       = (pc_rd == COUNT_MAX) ? pc_rd : pc_rd + 1'b1;
   assign vt_inc       = vt_rd + 1'b1;
   assign prob_clamped = (quotient > ONE_FIXED) ? ONE_FIXED : quotient;

   // The FSM returns to idle only after any write-back, so a read never
   // overlaps a pending write to the same entry.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pair_addr_in  = pair_addr_ff;
      val_addr_in   = val_addr_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_resp_in   = clr_resp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      res_prob_in   = res_prob_ff;
      res_pc_in     = res_pc_ff;
      res_vt_in     = res_vt_ff;
      res_status_in = res_status_ff;
      div_start     = 1'b0;
      pair_wr_en    = 1'b0;
      pair_wr_addr  = pair_addr_ff;
      pair_wr_data  = pc_inc;
      val_wr_en     = 1'b0;
      val_wr_addr   = val_addr_ff;
      val_wr_data   = vt_inc;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_op;
               pair_addr_in  = req_pair_addr;
               val_addr_in   = VAL_AW'(req_val);
               res_prob_in   = '0;
               res_pc_in     = '0;
               res_vt_in     = '0;
               res_status_in = ST_OK;
               unique case (req_op)
                  OP_ACCUM, OP_QUERY: begin
                     if (in_range) begin
                        state_in = S_EXEC;
                     end else begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     clr_cnt_in  = '0;
                     clr_resp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EXEC: begin
            if (op_ff == OP_ACCUM) begin
               if (vt_rd == COUNT_MAX) begin
                  res_status_in = ST_SAT;
                  res_pc_in     = OUT_COUNT_BITS'(pc_rd);
                  res_vt_in     = OUT_COUNT_BITS'(vt_rd);
               end else begin
                  pair_wr_en = 1'b1;
                  val_wr_en  = 1'b1;
                  res_pc_in  = OUT_COUNT_BITS'(pc_inc);
                  res_vt_in  = OUT_COUNT_BITS'(vt_inc);
               end
               state_in = S_DONE;
            end else begin
               res_pc_in = OUT_COUNT_BITS'(pc_rd);
               res_vt_in = OUT_COUNT_BITS'(vt_rd);
               if (vt_rd == '0) begin
                  state_in = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               res_prob_in = prob_clamped;
               state_in    = S_DONE;
            end
         end
         S_CLEAR: begin
            pair_wr_en   = 1'b1;
            pair_wr_addr = clr_cnt_ff;
            pair_wr_data = '0;
            val_wr_en    = int'(clr_cnt_ff) < MAX_VALUES;
            val_wr_addr  = VAL_AW'(clr_cnt_ff);
            val_wr_data  = '0;
            if (clr_cnt_ff == PAIR_AW'(PAIR_DEPTH - 1)) begin
               // The sweep after reset answers no item.
               state_in = clr_resp_ff ? S_DONE : S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, res_vt_ff, res_pc_ff, res_prob_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pair_addr_ff  <= pair_addr_in;
      val_addr_ff   <= val_addr_in;
      res_prob_ff   <= res_prob_in;
      res_pc_ff     <= res_pc_in;
      res_vt_ff     <= res_vt_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_wr_only_exec_clear : assert property (@(posedge clock) disable iff (reset)
      (pair_wr_en || val_wr_en) |-> (state_ff == S_EXEC || state_ff == S_CLEAR))
      else $error("count RAM written outside execute or clear");

   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished while no query was waiting");

   a_ready_div_idle : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("item accepted while the divider is busy");

   a_prob_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[PROB_BITS-1:0] <= ONE_FIXED))
      else $error("probability above 1.0");

   a_range_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == ST_RANGE) |-> (rsp_data_ff == '0))
      else $error("out-of-range item reports nonzero fields");

endmodule
